// ===== rtl/core/xrle_pkg.sv =====
// Shared types and constants for the XBIN cell run-length decoder.
package xrle_pkg;

	localparam int DATA_W     = 8;
	localparam int COL_W      = 11;
	localparam int ROW_W      = 16;
	localparam int RUN_W      = 7;
	localparam int CNT_W      = 6;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;
	localparam int MAX_WIDTH  = 1024;
	localparam int FIFO_DEPTH = 4;

	localparam logic [COL_W-1:0] COL_MAX = '1;

	localparam logic [CFG_IDX_W-1:0] REG_WIDTH      = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HEIGHT     = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_COMPRESSED = 2'd2;

	localparam logic [COL_W-1:0] RST_WIDTH  = 11'd80;
	localparam logic [ROW_W-1:0] RST_HEIGHT = 16'd25;

	typedef enum logic [1:0] {
		PH_HEAD   = 2'd0,
		PH_FIRST  = 2'd1,
		PH_SECOND = 2'd2,
		PH_ATTR   = 2'd3
	} phase_t;

	typedef enum logic [1:0] {
		MODE_RAW  = 2'd0,
		MODE_CHAR = 2'd1,
		MODE_ATTR = 2'd2,
		MODE_PAIR = 2'd3
	} mode_t;

	// one queued command: a group of identical cells from one byte
	typedef struct packed {
		logic [DATA_W-1:0] ch;
		logic [DATA_W-1:0] attr;
		logic [CNT_W-1:0]  count_m1;
		logic              wrap;
	} cmd_t;

endpackage

// ===== rtl/core/xrle_if.sv =====
// Handshake channel interfaces: byte input, cell output, register write.
interface xrle_byte_if;
	import xrle_pkg::*;
	logic              valid;
	logic              ready;
	logic [DATA_W-1:0] data_byte;
	modport source(output valid, output data_byte, input ready);
	modport sink(input valid, input data_byte, output ready);
endinterface

interface xrle_cell_if;
	import xrle_pkg::*;
	logic              valid;
	logic              ready;
	logic [DATA_W-1:0] cell_char;
	logic [DATA_W-1:0] cell_attr;
	logic [COL_W-1:0]  cell_column;
	logic [ROW_W-1:0]  cell_row;
	logic              run_last;
	logic              image_done;
	modport source(output valid, output cell_char, output cell_attr, output cell_column,
		output cell_row, output run_last, output image_done, input ready);
	modport sink(input valid, input cell_char, input cell_attr, input cell_column,
		input cell_row, input run_last, input image_done, output ready);
endinterface

interface xrle_cfg_if;
	import xrle_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  reg_index;
	logic [CFG_DATA_W-1:0] wdata;
	modport source(output valid, output reg_index, output wdata, input ready);
	modport sink(input valid, input reg_index, input wdata, output ready);
endinterface

// ===== rtl/core/xbin_cell_rle_decoder.sv =====
// Top level of the XBIN cell run-length decoder.
// Usage:
//   din  : image-data bytes, one word per valid/ready handshake.
//   dout : decoded cells (character, attribute, column, row, run_last, image_done).
//   cfg  : register writes, always ready; index 0 width, 1 height, 2 compressed.
//          Write only while the decoder is idle.
// Timing:
//   A byte is taken every cycle while the 4-entry command queue has room.
//   A byte that yields cells is written into the command queue, from which its
//   first cell is registered onto dout; cells leave at one per cycle while dout
//   is ready, so a shared-pair run of n cells holds the emitter until all n have
//   left. The emitter rate of one cell per cycle bounds sustained throughput.
// Reset:
//   arst_n clears parser phase, run state, column, row and the done flag;
//   registers return to width 80, height 25, compression on.
// Stalls:
//   If dout is not ready the output word holds, the emitter waits, and din
//   keeps being taken until the command queue fills.
//   After the final row completes every further byte is taken and dropped.
module xbin_cell_rle_decoder (
	input  logic         clk,
	input  logic         arst_n,
	xrle_byte_if.sink    din,
	xrle_cell_if.source  dout,
	xrle_cfg_if.sink     cfg
);
	import xrle_pkg::*;

	logic [COL_W-1:0] image_width_q;
	logic [ROW_W-1:0] image_height_q;
	logic             compressed_q;
	logic             push;
	cmd_t             push_cmd;
	logic             pop;
	cmd_t             head_cmd;
	logic             full;
	logic             empty;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_width_q  <= RST_WIDTH;
			image_height_q <= RST_HEIGHT;
			compressed_q   <= 1'b1;
		end else if (cfg.valid) begin
			unique case (cfg.reg_index)
				REG_WIDTH:      image_width_q  <= cfg.wdata[COL_W-1:0];
				REG_HEIGHT:     image_height_q <= cfg.wdata[ROW_W-1:0];
				REG_COMPRESSED: compressed_q   <= cfg.wdata[0];
				default:        ;
			endcase
		end
	end

	xrle_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.compressed (compressed_q),
		.din        (din),
		.fifo_full  (full),
		.push       (push),
		.push_cmd   (push_cmd)
	);

	xrle_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.pop      (pop),
		.head_cmd (head_cmd),
		.full     (full),
		.empty    (empty)
	);

	xrle_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.image_width  (image_width_q),
		.image_height (image_height_q),
		.head_cmd     (head_cmd),
		.empty        (empty),
		.pop          (pop),
		.dout         (dout)
	);

endmodule

// ===== rtl/core/xrle_fifo.sv =====
// Small command queue between the byte parser and the cell emitter.
module xrle_fifo (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  xrle_pkg::cmd_t push_cmd,
	input  logic           pop,
	output xrle_pkg::cmd_t head_cmd,
	output logic           full,
	output logic           empty
);
	import xrle_pkg::*;

	localparam int PTR_W = $clog2(FIFO_DEPTH);
	localparam int FCNT_W = $clog2(FIFO_DEPTH + 1);

	cmd_t              mem_q [FIFO_DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [FCNT_W-1:0] count_q;
	logic              do_push;
	logic              do_pop;

	assign full     = (count_q == FCNT_W'(FIFO_DEPTH));
	assign empty    = (count_q == '0);
	assign do_push  = push && !full;
	assign do_pop   = pop && !empty;
	assign head_cmd = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			if (do_pop)
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			if (do_push && !do_pop)
				count_q <= count_q + FCNT_W'(1);
			else if (do_pop && !do_push)
				count_q <= count_q - FCNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (do_push)
			mem_q[wr_ptr_q] <= push_cmd;
	end

endmodule

// ===== rtl/core/xrle_front.sv =====
// Byte parser: run headers, held character/attribute, cell commands to the queue.
module xrle_front (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           compressed,
	xrle_byte_if.sink      din,
	input  logic           fifo_full,
	output logic           push,
	output xrle_pkg::cmd_t push_cmd
);
	import xrle_pkg::*;

	phase_t            phase_q;
	phase_t            phase_d;
	mode_t             mode_q;
	mode_t             hdr_mode;
	logic [RUN_W-1:0]  run_left_q;
	logic [DATA_W-1:0] held_char_q;
	logic [DATA_W-1:0] held_attr_q;
	logic [DATA_W-1:0] b;
	logic              accept;
	logic              run_end;
	logic [CNT_W-1:0]  pair_cnt;

	assign din.ready = !fifo_full;
	assign accept    = din.valid && din.ready;
	assign b         = din.data_byte;
	assign hdr_mode  = mode_t'(b[7:6]);
	assign run_end   = (run_left_q <= RUN_W'(1));
	// a zero count (left over after a mode switch) still emits one cell
	assign pair_cnt  = (run_left_q == '0) ? '0 : CNT_W'(run_left_q - RUN_W'(1));

	// next phase
	always_comb begin
		phase_d = phase_q;
		if (accept) begin
			if (!compressed) begin
				phase_d = (phase_q == PH_ATTR) ? PH_HEAD : PH_ATTR;
			end else begin
				unique case (phase_q)
					PH_HEAD:   phase_d = (hdr_mode == MODE_RAW) ? PH_SECOND : PH_FIRST;
					PH_FIRST:  phase_d = PH_SECOND;
					PH_SECOND: begin
						unique case (mode_q)
							MODE_RAW:  phase_d = PH_ATTR;
							MODE_CHAR,
							MODE_ATTR: phase_d = run_end ? PH_HEAD : PH_SECOND;
							MODE_PAIR: phase_d = PH_HEAD;
							default:   phase_d = PH_HEAD;
						endcase
					end
					PH_ATTR:   phase_d = run_end ? PH_HEAD : PH_SECOND;
					default:   phase_d = PH_HEAD;
				endcase
			end
		end
	end

	// command output
	always_comb begin
		push              = 1'b0;
		push_cmd.ch       = held_char_q;
		push_cmd.attr     = b;
		push_cmd.count_m1 = '0;
		push_cmd.wrap     = run_end;
		if (accept) begin
			if (!compressed) begin
				push          = (phase_q == PH_ATTR);
				push_cmd.wrap = 1'b1;
			end else if (phase_q == PH_ATTR) begin
				push = 1'b1;
			end else if (phase_q == PH_SECOND) begin
				unique case (mode_q)
					MODE_RAW:  push = 1'b0;
					MODE_CHAR: push = 1'b1;
					MODE_ATTR: begin
						push          = 1'b1;
						push_cmd.ch   = b;
						push_cmd.attr = held_attr_q;
					end
					MODE_PAIR: begin
						push              = 1'b1;
						push_cmd.count_m1 = pair_cnt;
						push_cmd.wrap     = 1'b1;
					end
					default:   push = 1'b0;
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_HEAD;
			mode_q      <= MODE_RAW;
			run_left_q  <= '0;
			held_char_q <= '0;
			held_attr_q <= '0;
		end else begin
			phase_q <= phase_d;
			if (accept) begin
				if (!compressed) begin
					if (phase_q != PH_ATTR)
						held_char_q <= b;
				end else begin
					unique case (phase_q)
						PH_HEAD: begin
							mode_q     <= hdr_mode;
							run_left_q <= RUN_W'(b[5:0]) + RUN_W'(1);
						end
						PH_FIRST: begin
							if (mode_q == MODE_ATTR)
								held_attr_q <= b;
							else
								held_char_q <= b;
						end
						PH_SECOND: begin
							unique case (mode_q)
								MODE_RAW:  held_char_q <= b;
								MODE_CHAR,
								MODE_ATTR: run_left_q <= run_end ? '0 : run_left_q - RUN_W'(1);
								MODE_PAIR: begin
									held_attr_q <= b;
									run_left_q  <= '0;
								end
								default:   run_left_q <= '0;
							endcase
						end
						PH_ATTR:   run_left_q <= run_end ? '0 : run_left_q - RUN_W'(1);
						default:   run_left_q <= '0;
					endcase
				end
			end
		end
	end

endmodule

// ===== rtl/core/xrle_back.sv =====
// Cell emitter: expands queued commands into cells, tracks column, row and completion.
module xrle_back (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic [xrle_pkg::COL_W-1:0] image_width,
	input  logic [xrle_pkg::ROW_W-1:0] image_height,
	input  xrle_pkg::cmd_t             head_cmd,
	input  logic                       empty,
	output logic                       pop,
	xrle_cell_if.source                dout
);
	import xrle_pkg::*;

	logic [COL_W-1:0] col_q;
	logic [ROW_W-1:0] row_q;
	logic             done_q;
	logic [CNT_W-1:0] idx_q;
	logic             out_valid_q;
	logic             slot_free;
	logic             emit;
	logic             last;
	logic [COL_W-1:0] col_inc;
	logic [COL_W-1:0] width_lim;
	logic [ROW_W-1:0] row_inc;
	logic             wrap_hit;
	logic             fin;

	assign slot_free = !out_valid_q || dout.ready;
	assign emit      = !empty && !done_q && slot_free;
	assign last      = (idx_q == head_cmd.count_m1);
	// once the image is complete every later word is dropped
	assign pop       = !empty && (done_q || (slot_free && last));

	assign width_lim = (image_width > COL_W'(MAX_WIDTH)) ? COL_W'(MAX_WIDTH) : image_width;
	assign col_inc   = (col_q == COL_MAX) ? col_q : col_q + COL_W'(1);
	assign row_inc   = row_q + ROW_W'(1);
	assign wrap_hit  = last && head_cmd.wrap && (col_inc >= width_lim);
	assign fin       = wrap_hit && ((row_inc >= image_height) || (row_inc == '0));

	assign dout.valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q       <= '0;
			row_q       <= '0;
			done_q      <= 1'b0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (dout.ready)
				out_valid_q <= 1'b0;
			if (emit) begin
				out_valid_q <= 1'b1;
				idx_q       <= last ? '0 : idx_q + CNT_W'(1);
				col_q       <= wrap_hit ? '0 : col_inc;
				if (wrap_hit)
					row_q <= row_inc;
				if (fin)
					done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			dout.cell_char   <= head_cmd.ch;
			dout.cell_attr   <= head_cmd.attr;
			dout.cell_column <= col_q;
			dout.cell_row    <= row_q;
			dout.run_last    <= last;
			dout.image_done  <= fin;
		end
	end

endmodule

// ===== verif/xrle_cell_checker.sv =====
// Cell checker: tracks decoder registers and parse state, predicts cells and compares dout.
`timescale 1ns / 1ps
module xrle_cell_checker (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            byte_valid,
	input  logic                            byte_ready,
	input  logic [xrle_pkg::DATA_W-1:0]     data_byte,
	input  logic                            cell_valid,
	input  logic                            cell_ready,
	input  logic [xrle_pkg::DATA_W-1:0]     cell_char,
	input  logic [xrle_pkg::DATA_W-1:0]     cell_attr,
	input  logic [xrle_pkg::COL_W-1:0]      cell_column,
	input  logic [xrle_pkg::ROW_W-1:0]      cell_row,
	input  logic                            run_last,
	input  logic                            image_done,
	input  logic                            cfg_valid,
	input  logic                            cfg_ready,
	input  logic [xrle_pkg::CFG_IDX_W-1:0]  reg_index,
	input  logic [xrle_pkg::CFG_DATA_W-1:0] wdata,
	output int                              mismatches,
	output int                              cells_pending
);
	import xrle_pkg::*;

	typedef struct packed {
		logic [DATA_W-1:0] ch;
		logic [DATA_W-1:0] attr;
		logic [COL_W-1:0]  column;
		logic [ROW_W-1:0]  row;
		logic              last;
		logic              done;
	} cell_t;

	logic [COL_W-1:0]  width_q;
	logic [ROW_W-1:0]  height_q;
	logic              comp_q;

	phase_t            ph;
	mode_t             mode;
	logic [RUN_W-1:0]  run_left;
	logic [DATA_W-1:0] held_ch;
	logic [DATA_W-1:0] held_at;
	logic [COL_W-1:0]  cur_col;
	logic [ROW_W-1:0]  cur_row;
	logic              finished;

	cell_t cells_due[$];

	task automatic push_cell(input logic [DATA_W-1:0] ch, input logic [DATA_W-1:0] at,
		input logic last);
		cell_t c;
		c.ch     = ch;
		c.attr   = at;
		c.column = cur_col;
		c.row    = cur_row;
		c.last   = last;
		c.done   = 1'b0;
		cells_due.push_back(c);
		if (cur_col != COL_MAX)
			cur_col = cur_col + 1'b1;
	endtask

	// run end: wrap the row once the column reached the width, mark image completion
	task automatic end_of_run();
		logic [COL_W-1:0] w;
		cell_t c;
		w = (width_q > MAX_WIDTH) ? COL_W'(MAX_WIDTH) : width_q;
		if (cur_col >= w) begin
			cur_col = '0;
			cur_row = cur_row + 1'b1;
			if (cur_row >= height_q || cur_row == '0) begin
				finished = 1'b1;
				c = cells_due.pop_back();
				c.done = 1'b1;
				cells_due.push_back(c);
			end
		end
	endtask

	task automatic close_cell();
		if (run_left <= 1) begin
			run_left = '0;
			ph = PH_HEAD;
			end_of_run();
		end else begin
			run_left = run_left - 1'b1;
		end
	endtask

	task automatic decode_byte(input logic [DATA_W-1:0] b);
		int n;
		int k;
		if (finished)
			return;
		if (!comp_q) begin
			// plain pairs: PH_ATTR means the attribute is next
			if (ph == PH_ATTR) begin
				push_cell(held_ch, b, 1'b1);
				ph = PH_HEAD;
				end_of_run();
			end else begin
				held_ch = b;
				ph = PH_ATTR;
			end
			return;
		end
		case (ph)
			PH_HEAD: begin
				mode = mode_t'(b[7:6]);
				run_left = {1'b0, b[5:0]} + 1'b1;
				ph = (mode == MODE_RAW) ? PH_SECOND : PH_FIRST;
			end
			PH_FIRST: begin
				if (mode == MODE_ATTR)
					held_at = b;
				else
					held_ch = b;
				ph = PH_SECOND;
			end
			PH_SECOND: begin
				case (mode)
					MODE_RAW: begin
						held_ch = b;
						ph = PH_ATTR;
					end
					MODE_CHAR: begin
						push_cell(held_ch, b, 1'b1);
						close_cell();
					end
					MODE_ATTR: begin
						push_cell(b, held_at, 1'b1);
						close_cell();
					end
					default: begin
						// shared pair: whole run at once, zero count acts as one cell
						n = (run_left == 0) ? 1 : ((run_left > 64) ? 64 : int'(run_left));
						held_at = b;
						for (k = 0; k < n; k++)
							push_cell(held_ch, held_at, k == n - 1);
						run_left = '0;
						ph = PH_HEAD;
						end_of_run();
					end
				endcase
			end
			default: begin
				// attribute of a raw pair, whatever the mode holds
				push_cell(held_ch, b, 1'b1);
				ph = PH_SECOND;
				close_cell();
			end
		endcase
	endtask

	task automatic check_cell();
		cell_t got;
		cell_t want;
		got.ch     = cell_char;
		got.attr   = cell_attr;
		got.column = cell_column;
		got.row    = cell_row;
		got.last   = run_last;
		got.done   = image_done;
		if (cells_due.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("%0t unexpected cell: char %h attr %h col %0d row %0d last %b done %b",
					$time, got.ch, got.attr, got.column, got.row, got.last, got.done);
		end else begin
			want = cells_due.pop_front();
			if (got !== want) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("%0t cell mismatch, expected: char %h attr %h col %0d row %0d last %b done %b",
						$time, want.ch, want.attr, want.column, want.row, want.last, want.done);
					$display("%0t                 actual: char %h attr %h col %0d row %0d last %b done %b",
						$time, got.ch, got.attr, got.column, got.row, got.last, got.done);
				end
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q = RST_WIDTH;
			height_q = RST_HEIGHT;
			comp_q = 1'b1;
			ph = PH_HEAD;
			mode = MODE_RAW;
			run_left = '0;
			held_ch = '0;
			held_at = '0;
			cur_col = '0;
			cur_row = '0;
			finished = 1'b0;
			cells_due.delete();
			mismatches = 0;
			cells_pending = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (reg_index)
					REG_WIDTH:      width_q = wdata[COL_W-1:0];
					REG_HEIGHT:     height_q = wdata[ROW_W-1:0];
					REG_COMPRESSED: comp_q = wdata[0];
					default: ;
				endcase
			end
			if (byte_valid && byte_ready)
				decode_byte(data_byte);
			if (cell_valid && cell_ready)
				check_cell();
			cells_pending = cells_due.size();
		end
	end

endmodule

// ===== verif/tb_xbin_cell_rle_decoder.sv =====
// Testbench top: clock, reset, register writes, byte stimulus, output back-pressure, verdict.
`timescale 1ns / 1ps
module tb_xbin_cell_rle_decoder;
	import xrle_pkg::*;

	localparam int CYCLE_LIMIT = 500000;
	localparam int HOLD_CYCLES = 200;

	logic clk;
	logic arst_n;
	logic image_seen = 1'b0;
	int   src_idle_pct = 0;
	int   snk_idle_pct = 0;
	int   hold_req = 0;
	int   cycle_count = 0;
	int   bytes_sent = 0;
	int   mismatches;
	int   cells_pending;

	xrle_byte_if din();
	xrle_cell_if dout();
	xrle_cfg_if  cfg();

	xbin_cell_rle_decoder dut (
		.clk    (clk),
		.arst_n (arst_n),
		.din    (din),
		.dout   (dout),
		.cfg    (cfg)
	);

	xrle_cell_checker chk (
		.clk           (clk),
		.arst_n        (arst_n),
		.byte_valid    (din.valid),
		.byte_ready    (din.ready),
		.data_byte     (din.data_byte),
		.cell_valid    (dout.valid),
		.cell_ready    (dout.ready),
		.cell_char     (dout.cell_char),
		.cell_attr     (dout.cell_attr),
		.cell_column   (dout.cell_column),
		.cell_row      (dout.cell_row),
		.run_last      (dout.run_last),
		.image_done    (dout.image_done),
		.cfg_valid     (cfg.valid),
		.cfg_ready     (cfg.ready),
		.reg_index     (cfg.reg_index),
		.wdata         (cfg.wdata),
		.mismatches    (mismatches),
		.cells_pending (cells_pending)
	);

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("tb_xbin_cell_rle_decoder: done, errors");
			$finish;
		end
	end

	always @(posedge clk)
		if (dout.valid && dout.ready && dout.image_done)
			image_seen <= 1'b1;

	// receiver: random stalls, plus a long hold-off on request
	initial begin
		int hold_seen;
		hold_seen = 0;
		dout.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req != hold_seen) begin
				hold_seen = hold_req;
				dout.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			dout.ready <= ($urandom_range(0, 99) >= snk_idle_pct);
		end
	end

	task automatic send_byte(input logic [DATA_W-1:0] b);
		while ($urandom_range(0, 99) < src_idle_pct) begin
			din.valid <= 1'b0;
			@(posedge clk);
		end
		din.valid <= 1'b1;
		din.data_byte <= b;
		do @(posedge clk); while (!din.ready);
		bytes_sent++;
	endtask

	task automatic send_header(input mode_t m, input int len);
		send_byte({m, 6'(len - 1)});
	endtask

	// one well-formed run with random content, mostly short
	task automatic send_run();
		mode_t m;
		int len;
		m = mode_t'($urandom_range(0, 3));
		case ($urandom_range(0, 9))
			0:       len = 64;
			1:       len = $urandom_range(1, 64);
			default: len = $urandom_range(1, 6);
		endcase
		send_header(m, len);
		case (m)
			MODE_RAW: begin
				repeat (2 * len) send_byte(8'($urandom));
			end
			MODE_CHAR, MODE_ATTR: begin
				repeat (len + 1) send_byte(8'($urandom));
			end
			default: begin
				send_byte(8'($urandom));
				send_byte(8'($urandom));
			end
		endcase
	endtask

	// mostly runs, some stray bytes that knock the parser out of frame
	task automatic send_runs(input int count);
		int start;
		start = bytes_sent;
		while (bytes_sent - start < count) begin
			if ($urandom_range(0, 99) < 12)
				send_byte(8'($urandom));
			else
				send_run();
		end
	endtask

	task automatic send_noise(input int count);
		repeat (count) send_byte(8'($urandom));
	endtask

	// let the output drain, then give the parser time to go quiet
	task automatic settle();
		din.valid <= 1'b0;
		@(posedge clk);
		while (cells_pending != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_regs(input logic [COL_W-1:0] w, input logic [ROW_W-1:0] h,
		input logic comp);
		cfg.valid <= 1'b1;
		cfg.reg_index <= REG_WIDTH;
		cfg.wdata <= {5'($urandom), w};
		do @(posedge clk); while (!cfg.ready);
		cfg.reg_index <= REG_HEIGHT;
		cfg.wdata <= h;
		do @(posedge clk); while (!cfg.ready);
		cfg.reg_index <= REG_COMPRESSED;
		cfg.wdata <= {15'($urandom), comp};
		do @(posedge clk); while (!cfg.ready);
		cfg.valid <= 1'b0;
	endtask

	initial begin
		int tail;
		arst_n = 1'b0;
		din.valid = 1'b0;
		din.data_byte = '0;
		cfg.valid = 1'b0;
		cfg.reg_index = REG_WIDTH;
		cfg.wdata = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		src_idle_pct = 33;
		snk_idle_pct = 63;
		write_regs(11'd4, 16'hFFFF, 1'b1);

		// every mode, byte extremes, a full 64-cell pair run that runs past the width
		send_header(MODE_RAW, 1);
		send_byte(8'h00);
		send_byte(8'hFF);
		send_header(MODE_CHAR, 2);
		send_byte(8'hFF);
		send_byte(8'h00);
		send_byte(8'h80);
		send_header(MODE_ATTR, 1);
		send_byte(8'h55);
		send_byte(8'hAA);
		send_header(MODE_PAIR, 64);
		send_byte(8'h01);
		send_byte(8'hFE);
		send_header(MODE_PAIR, 1);
		send_byte(8'h7F);
		send_byte(8'h80);
		send_header(MODE_RAW, 2);
		send_noise(4);
		send_runs(90);

		// zero width: every run end wraps
		settle();
		write_regs(11'd0, 16'hFFFF, 1'b1);
		send_runs(50);

		// uncompressed, width over the cap; switch lands mid-run
		settle();
		src_idle_pct = 63;
		snk_idle_pct = 33;
		write_regs(11'h7FF, 16'd40000, 1'b0);
		send_noise(60);

		settle();
		write_regs(11'd1024, 16'hFFFF, 1'b1);
		send_runs(80);

		settle();
		src_idle_pct = 0;
		snk_idle_pct = 0;
		write_regs(11'd1, 16'hFFFF, 1'b0);
		send_noise(30);

		// receiver holds off while bytes keep coming
		settle();
		write_regs(11'($urandom_range(1, 200)), 16'hFFFF, 1'b1);
		hold_req++;
		send_runs(80);

		// zero height: the next row end completes the image, later bytes are dropped
		settle();
		write_regs(11'd1, 16'd0, 1'b1);
		tail = 0;
		while (!image_seen && tail < 300) begin
			send_run();
			tail++;
		end
		send_noise(10);

		settle();
		repeat (20) @(posedge clk);
		if (mismatches == 0 && cells_pending == 0)
			$display("tb_xbin_cell_rle_decoder: done, clean");
		else
			$display("tb_xbin_cell_rle_decoder: done, errors");
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/core/xrle_pkg.sv
rtl/core/xrle_if.sv
rtl/core/xrle_fifo.sv
rtl/core/xrle_front.sv
rtl/core/xrle_back.sv
rtl/core/xbin_cell_rle_decoder.sv
verif/xrle_cell_checker.sv
verif/tb_xbin_cell_rle_decoder.sv
